// ===== design/ulch_pkg.sv =====
// Package for the unique ID list with cursor history.
// Holds sizes, command and cell-mode codes, and the chain control struct.
// No dependencies.
`default_nettype none

package ulch_pkg;

  // Sizes
  localparam int MAX_ENTRIES   = 64;
  localparam int HISTORY_DEPTH = 6;
  localparam int ID_W          = 32;
  localparam int IDX_W         = $clog2(MAX_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
  localparam int HIST_W        = $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int CMD_W         = 3;
  localparam int CAP_W         = 7;

  localparam logic [CAP_W-1:0] CAP_DEFAULT = CAP_W'(20);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PREV   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd5;

  // Cell modes
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_ROTATE = 2'd1;
  localparam logic [1:0] MODE_APPLY  = 2'd2;

  // Control from the sequencer to the cell chain
  typedef struct packed {
    logic [1:0]       mode;
    logic             load_en;
    logic [IDX_W-1:0] load_pos;
    logic             shift_en;
    logic [IDX_W-1:0] shift_pos;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== design/ulch_cell.sv =====
// One storage cell of the ID chain: holds one 32-bit entry.
// Rotates from, or closes a gap with, its right neighbor. Uses ulch_pkg.
`default_nettype none

module ulch_cell (
  input  wire logic                      clk,
  input  wire logic [1:0]                mode,
  input  wire logic                      load_sel,
  input  wire logic                      shift_sel,
  input  wire logic [ulch_pkg::ID_W-1:0] load_data,
  input  wire logic [ulch_pkg::ID_W-1:0] right_data,
  output logic      [ulch_pkg::ID_W-1:0] data
);

  // Take the neighbor on rotate, load or close the gap on apply, else hold
  always_ff @(posedge clk) begin
    case (mode)
      ulch_pkg::MODE_ROTATE: begin
        data <= right_data;
      end
      ulch_pkg::MODE_APPLY: begin
        if (load_sel) begin
          data <= load_data;
        end else if (shift_sel) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ulch_chain.sv =====
// Ring of ulch_cell instances holding the ID list; cell 0 is the read head.
// Decodes per-cell load and shift selects. Uses ulch_pkg and ulch_cell.
`default_nettype none

module ulch_chain (
  input  wire logic                      clk,
  input  wire ulch_pkg::chain_ctrl_t     ctrl,
  input  wire logic [ulch_pkg::ID_W-1:0] load_data,
  output logic      [ulch_pkg::ID_W-1:0] head
);

  logic [ulch_pkg::ID_W-1:0] cells [ulch_pkg::MAX_ENTRIES];

  genvar i;
  generate
    for (i = 0; i < ulch_pkg::MAX_ENTRIES; i++) begin : g_cell
      logic load_sel;
      logic shift_sel;

      // Load at the tail slot, shift down every slot at or above the gap
      assign load_sel  = ctrl.load_en &&
                         (ctrl.load_pos == ulch_pkg::IDX_W'(i));
      assign shift_sel = ctrl.shift_en &&
                         (ulch_pkg::IDX_W'(i) >= ctrl.shift_pos);

      ulch_cell u_cell (
        .clk        (clk),
        .mode       (ctrl.mode),
        .load_sel   (load_sel),
        .shift_sel  (shift_sel),
        .load_data  (load_data),
        .right_data (cells[(i + 1) % ulch_pkg::MAX_ENTRIES]),
        .data       (cells[i])
      );
    end
  endgenerate

  assign head = cells[0];

endmodule

`default_nettype wire

// ===== design/unique_list_with_cursor_history_top.sv =====
// Add and remove first scan the 64-cell ring for a duplicate or a match as each
// entry passes the head, then apply the update, rotate the ring once more to read
// the entry under the cursor, and register the result; other commands skip the
// scan. A new request is taken only after the previous result has been offered.
// Synchronous reset empties the list, zeroes cursor and history, and sets
// capacity to 20; no clearing pass.
`default_nettype none

module unique_list_with_cursor_history_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: capacity
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // song_id[31:0], index[37:32], premium[38]
  input  wire logic [2:0]  s_tuser,   // cmd[2:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // ok[0], current_id[32:1], cursor_pos[38:33],
                                      // entry_count[45:39]
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int IDX_W  = ulch_pkg::IDX_W;
  localparam int CNT_W  = ulch_pkg::CNT_W;
  localparam int HIST_W = ulch_pkg::HIST_W;
  localparam int FILL_W = ulch_pkg::FILL_W;
  localparam int ID_W   = ulch_pkg::ID_W;

  localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(ulch_pkg::MAX_ENTRIES - 1);
  localparam logic [HIST_W-1:0] LAST_SLOT = HIST_W'(ulch_pkg::HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ulch_pkg::HISTORY_DEPTH);

  logic [2:0]                  state;
  logic [IDX_W-1:0]            step;
  logic [ulch_pkg::CMD_W-1:0]  cmd;
  logic [ID_W-1:0]             req_id;
  logic [IDX_W-1:0]            req_idx;
  logic                        premium;
  logic                        found;
  logic [IDX_W-1:0]            match_pos;
  logic [CNT_W-1:0]            count;
  logic [IDX_W-1:0]            cursor;
  logic [ulch_pkg::CAP_W-1:0]  capacity;
  logic [IDX_W-1:0]            ring [ulch_pkg::HISTORY_DEPTH];
  logic [HIST_W-1:0]           wr_ptr;
  logic [FILL_W-1:0]           fill;
  logic                        ok;
  logic [ID_W-1:0]             cur_id;

  logic [CNT_W-1:0]            count_next;
  logic [IDX_W-1:0]            cursor_next;
  logic [HIST_W-1:0]           wr_ptr_next;
  logic [FILL_W-1:0]           fill_next;
  logic                        ok_next;
  logic                        ring_we;
  logic [CNT_W-1:0]            eff_cap;
  logic [HIST_W-1:0]           wr_ptr_prev;
  logic [IDX_W-1:0]            restored;
  logic [CNT_W-1:0]            count_dec;
  logic                        add_go;
  logic                        remove_go;
  logic [ID_W-1:0]             head;
  ulch_pkg::chain_ctrl_t       ctrl;

  assign s_tready = (state == ST_IDLE) && !rst;

  // Capacity as used: zero means default, saturate at the list size
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(ulch_pkg::CAP_DEFAULT);
    end else if (capacity > ulch_pkg::CAP_W'(ulch_pkg::MAX_ENTRIES)) begin
      eff_cap = CNT_W'(ulch_pkg::MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign add_go      = (cmd == ulch_pkg::CMD_ADD) && !found && (count < eff_cap);
  assign remove_go   = (cmd == ulch_pkg::CMD_REMOVE) && found;
  assign wr_ptr_prev = (wr_ptr == '0) ? LAST_SLOT : wr_ptr - HIST_W'(1);
  assign count_dec   = count - CNT_W'(1);

  // Work out the list, cursor and history update for the held request
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    ok_next     = 1'b0;
    ring_we     = 1'b0;
    case (cmd)
      ulch_pkg::CMD_ADD: begin
        if (add_go) begin
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      ulch_pkg::CMD_REMOVE: begin
        if (remove_go) begin
          count_next = count_dec;
          if (CNT_W'(cursor) >= count_dec) begin
            cursor_next = '0;
          end
          ok_next = 1'b1;
        end
      end
      ulch_pkg::CMD_PLAY: begin
        ok_next = (count != '0);
      end
      ulch_pkg::CMD_NEXT: begin
        if (count != '0) begin
          ring_we     = 1'b1;
          wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + HIST_W'(1);
          if (fill < FULL_FILL) begin
            fill_next = fill + FILL_W'(1);
          end
          cursor_next = (CNT_W'(cursor) + CNT_W'(1) >= count) ?
                        '0 : cursor + IDX_W'(1);
          ok_next     = 1'b1;
        end
      end
      ulch_pkg::CMD_PREV: begin
        if (premium && (fill != '0)) begin
          wr_ptr_next = wr_ptr_prev;
          cursor_next = (CNT_W'(restored) >= count) ? '0 : restored;
          fill_next   = fill - FILL_W'(1);
        end
        ok_next = (count != '0);
      end
      ulch_pkg::CMD_SET: begin
        if (CNT_W'(req_idx) < count) begin
          cursor_next = req_idx;
          ok_next     = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Drive the cell chain
  always_comb begin
    ctrl.mode      = ulch_pkg::MODE_HOLD;
    ctrl.load_en   = 1'b0;
    ctrl.load_pos  = count[IDX_W-1:0];
    ctrl.shift_en  = 1'b0;
    ctrl.shift_pos = match_pos;
    case (state)
      ST_SCAN, ST_READ: begin
        ctrl.mode = ulch_pkg::MODE_ROTATE;
      end
      ST_APPLY: begin
        ctrl.mode     = ulch_pkg::MODE_APPLY;
        ctrl.load_en  = add_go;
        ctrl.shift_en = remove_go;
      end
      default: begin
        ctrl.mode = ulch_pkg::MODE_HOLD;
      end
    endcase
  end

  ulch_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_data (req_id),
    .head      (head)
  );

  // Sequencer, list bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      count    <= '0;
      cursor   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      capacity <= ulch_pkg::CAP_DEFAULT;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      // Drop the taken result unless a new one replaces it
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          step  <= '0;
          found <= 1'b0;
          if (s_tvalid) begin
            if ((s_tuser == ulch_pkg::CMD_ADD) || (s_tuser == ulch_pkg::CMD_REMOVE)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_APPLY;
            end
          end
        end
        ST_SCAN: begin
          // Note the first stored match as it passes the head
          if (!found && (CNT_W'(step) < count) && (head == req_id)) begin
            found     <= 1'b1;
            match_pos <= step;
          end
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          count  <= count_next;
          cursor <= cursor_next;
          wr_ptr <= wr_ptr_next;
          fill   <= fill_next;
          ok     <= ok_next;
          step   <= '0;
          state  <= ST_READ;
        end
        ST_READ: begin
          // Catch the entry under the cursor as it passes the head
          if (step == cursor) begin
            cur_id <= head;
          end
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the request payload on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd     <= s_tuser;
      req_id  <= s_tdata[31:0];
      req_idx <= s_tdata[37:32];
      premium <= s_tdata[38];
    end
  end

  // Save the cursor in the history ring on next; fetch the newest saved slot
  always_ff @(posedge clk) begin
    if ((state == ST_APPLY) && ring_we) begin
      ring[wr_ptr] <= cursor;
    end
    restored <= ring[wr_ptr_prev];
  end

  // Pack the result
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, count, cursor, (count != '0) ? cur_id : {ID_W{1'b0}}, ok};
    end
  end

endmodule

`default_nettype wire

// ===== design/ulch_checker.sv =====
// Port-level checker for the unique ID list with cursor history.
// Bound to unique_list_with_cursor_history_top; no package dependency.
`default_nettype none

module ulch_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [6:0]  cfg_wdata,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic [2:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);

  // Result is not offered in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Stored count never exceeds the list size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[45:39] <= 7'd64))
    else $error("entry_count out of range");

  // Cursor points inside a nonempty list, and rests at zero on an empty one
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[45:39] == 7'd0) ? (m_tdata[38:33] == 6'd0)
                                           : ({1'b0, m_tdata[38:33]} < m_tdata[45:39])))
    else $error("cursor_pos outside the list");

  // An empty list reports ID zero
  a_empty_id: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[45:39] == 7'd0)) |-> (m_tdata[32:1] == 32'd0))
    else $error("nonzero current_id on an empty list");

endmodule

bind unique_list_with_cursor_history_top ulch_checker u_ulch_checker (.*);

`default_nettype wire

// ===== tb/playlist_checker.sv =====
`timescale 1ns / 1ps
// Checker for the unique ID list with cursor history: watches the capacity
// write port and the request and result streams, predicts each result and compares.
// Depends on ulch_pkg for sizes, command codes and the capacity default.

module playlist_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,   // song_id[31:0], index[37:32], premium[38]
  input  wire logic [2:0]  s_tuser,   // cmd[2:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,   // ok[0], current_id[32:1], cursor_pos[38:33],
                                      // entry_count[45:39]
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [ulch_pkg::CNT_W-1:0] entry_count;
    logic [ulch_pkg::IDX_W-1:0] cursor_pos;
    logic [ulch_pkg::ID_W-1:0]  current_id;
    logic                       ok;
  } list_view_t;

  // Shadow copy of the list, cursor, history and capacity
  logic [ulch_pkg::ID_W-1:0]  ids [ulch_pkg::MAX_ENTRIES];
  logic [ulch_pkg::IDX_W-1:0] saved_pos [ulch_pkg::HISTORY_DEPTH];
  int unsigned                n_ids;
  int unsigned                cur;
  int unsigned                hist_wr;
  int unsigned                hist_fill;
  logic [ulch_pkg::CAP_W-1:0] capacity;
  list_view_t                 expected_views [$];

  // Zero falls back to the default, anything past the array saturates
  function automatic int unsigned add_limit();
    int unsigned c;
    c = capacity;
    if (c == 0) c = ulch_pkg::CAP_DEFAULT;
    if (c > ulch_pkg::MAX_ENTRIES) c = ulch_pkg::MAX_ENTRIES;
    return c;
  endfunction

  // Apply one request to the shadow state and return the view after it
  task automatic apply_request(input logic [ulch_pkg::CMD_W-1:0] cmd,
                               input logic [ulch_pkg::ID_W-1:0] id,
                               input logic [ulch_pkg::IDX_W-1:0] idx, input logic prem,
                               output list_view_t view);
    int unsigned pos;
    bit          found;
    logic        ok;
    found = 0;
    pos   = 0;
    ok    = 1'b0;
    for (int i = 0; i < n_ids; i++) begin
      if (!found && ids[i] == id) begin
        found = 1;
        pos   = i;
      end
    end
    case (cmd)
      ulch_pkg::CMD_ADD: begin
        if (!found && n_ids < add_limit()) begin
          ids[n_ids] = id;
          n_ids++;
          ok = 1'b1;
        end
      end
      ulch_pkg::CMD_REMOVE: begin
        if (found) begin
          for (int i = pos; i + 1 < n_ids; i++) ids[i] = ids[i + 1];
          n_ids--;
          if (cur >= n_ids) cur = 0;
          ok = 1'b1;
        end
      end
      ulch_pkg::CMD_PLAY: ok = n_ids > 0;
      ulch_pkg::CMD_NEXT: begin
        if (n_ids > 0) begin
          saved_pos[hist_wr] = ulch_pkg::IDX_W'(cur);
          hist_wr = (hist_wr + 1 >= ulch_pkg::HISTORY_DEPTH) ? 0 : hist_wr + 1;
          if (hist_fill < ulch_pkg::HISTORY_DEPTH) hist_fill++;
          cur = (cur + 1 >= n_ids) ? 0 : cur + 1;
          ok = 1'b1;
        end
      end
      ulch_pkg::CMD_PREV: begin
        if (prem && hist_fill > 0) begin
          hist_wr = (hist_wr == 0) ? ulch_pkg::HISTORY_DEPTH - 1 : hist_wr - 1;
          cur = saved_pos[hist_wr];
          if (cur >= n_ids) cur = 0;
          hist_fill--;
        end
        ok = n_ids > 0;
      end
      ulch_pkg::CMD_SET: begin
        if (idx < n_ids) begin
          cur = idx;
          ok  = 1'b1;
        end
      end
      default: ;
    endcase
    view.ok          = ok;
    view.current_id  = (n_ids > 0 && cur < n_ids) ? ids[cur] : '0;
    view.cursor_pos  = ulch_pkg::IDX_W'(cur);
    view.entry_count = ulch_pkg::CNT_W'(n_ids);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s field mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin : watch
    list_view_t want;
    list_view_t got;
    list_view_t pred;
    if (rst) begin
      n_ids      = 0;
      cur        = 0;
      hist_wr    = 0;
      hist_fill  = 0;
      capacity   = ulch_pkg::CAP_DEFAULT;
      fail_count = 0;
      expected_views.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      // compare the delivered result with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(list_view_t)-1:0];
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("current_id", want.current_id, got.current_id);
          check_field("cursor_pos", 32'(want.cursor_pos), 32'(got.cursor_pos));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        end
      end
      // predict the result of each accepted request
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser, s_tdata[31:0], s_tdata[37:32], s_tdata[38], pred);
        expected_views.push_back(pred);
      end
    end
    pending = expected_views.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the unique ID list with cursor history: clock,
// reset, request and capacity stimulus, result back-pressure and verdict.
// Depends on ulch_pkg, unique_list_with_cursor_history_top and playlist_checker.

module testbench;

  // Command codes the block treats as no-ops
  localparam logic [ulch_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [ulch_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int POOL_SIZE   = 96;
  localparam int PHASE_ITEMS = 150;
  localparam int N_PHASES    = 7;
  localparam logic [ulch_pkg::CAP_W-1:0] PHASE_CAP [N_PHASES] =
    '{0, 1, 64, 127, 100, 5, 33};
  localparam int PHASE_ADD_PCT [N_PHASES] = '{35, 35, 60, 35, 30, 20, 15};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [47:0] m_tdata;

  int          fail_count;
  int          pending;
  bit          tx_quiet;
  logic [31:0] id_pool [POOL_SIZE];
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 0;

  unique_list_with_cursor_history_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  playlist_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Offer one request, with an occasional idle gap first, and hold it until taken
  task automatic send_req(input logic [ulch_pkg::CMD_W-1:0] cmd, input logic [31:0] id,
                          input logic [5:0] idx, input logic prem);
    int gap;
    gap = 0;
    if (!tx_quiet && $urandom_range(0, 99) < 11) gap = $urandom_range(1, 140);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, prem, idx, id};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain all outstanding requests, then write the capacity register
  task automatic write_capacity(input logic [ulch_pkg::CAP_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random requests over a pool of IDs so duplicates and removes hit often
  task automatic run_phase(input int items, input int add_pct);
    logic [ulch_pkg::CMD_W-1:0] cmd;
    logic [31:0]                id;
    logic [5:0]                 idx;
    logic                       prem;
    int                         pick;
    for (int k = 0; k < items; k++) begin
      id   = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, POOL_SIZE - 1)];
      idx  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
      prem = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 99) < add_pct) begin
        cmd = ulch_pkg::CMD_ADD;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = ulch_pkg::CMD_REMOVE;
        else if (pick < 42) cmd = ulch_pkg::CMD_PLAY;
        else if (pick < 64) cmd = ulch_pkg::CMD_NEXT;
        else if (pick < 84) cmd = ulch_pkg::CMD_PREV;
        else if (pick < 96) cmd = ulch_pkg::CMD_SET;
        else if (pick < 98) cmd = CMD_SPARE_LO;
        else                cmd = CMD_SPARE_HI;
      end
      send_req(cmd, id, idx, prem);
    end
  endtask

  // Result side: random stalls, one long hold-off, and a stretch with none
  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_seen++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (results_seen == 100 && !hold_done) begin
      hold_done = 1;
      hold_left = 2000;
      m_tready <= 1'b0;
    end else if (results_seen >= 400 && results_seen < 600) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= $urandom_range(0, 99) >= 11;
    end
  end

  // Stimulus and verdict
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom();
    tx_quiet = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty list: play, next, previous, remove and set all see nothing
    send_req(ulch_pkg::CMD_PLAY, 32'h0, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_NEXT, 32'h0, 6'd0, 1'b1);
    send_req(ulch_pkg::CMD_PREV, 32'h0, 6'd0, 1'b1);
    send_req(ulch_pkg::CMD_REMOVE, 32'h0000_1234, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_SET, 32'h0, 6'd0, 1'b1);
    // extreme IDs, then a duplicate add
    send_req(ulch_pkg::CMD_ADD, 32'h0000_0000, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_req(ulch_pkg::CMD_ADD, 32'h0000_0000, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_ADD, 32'hA5A5_5A5A, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_ADD, 32'h0000_0001, 6'd0, 1'b0);
    // set cursor out of range, then in range
    send_req(ulch_pkg::CMD_SET, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_req(ulch_pkg::CMD_SET, 32'h0, 6'd2, 1'b0);
    // next with wrap, and enough steps to overwrite the oldest history slot
    repeat (7) send_req(ulch_pkg::CMD_NEXT, 32'h0, 6'd0, 1'b0);
    // previous without premium is refused, with premium it restores
    send_req(ulch_pkg::CMD_PREV, 32'h0, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_PREV, 32'h0, 6'd0, 1'b1);
    // restored position past the shrunken list reads as zero
    send_req(ulch_pkg::CMD_SET, 32'h0, 6'd3, 1'b0);
    send_req(ulch_pkg::CMD_NEXT, 32'h0, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_REMOVE, 32'h0000_0001, 6'd0, 1'b0);
    send_req(ulch_pkg::CMD_PREV, 32'h0, 6'd0, 1'b1);
    // removal of the first entry closes the gap
    send_req(ulch_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0, 1'b0);
    // unused command codes change nothing
    send_req(CMD_SPARE_LO, $urandom(), 6'($urandom_range(0, 63)), 1'b1);
    send_req(CMD_SPARE_HI, $urandom(), 6'($urandom_range(0, 63)), 1'b0);

    // random phases over several capacity settings
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(PHASE_CAP[p]);
      tx_quiet = (p == 3);
      run_phase(PHASE_ITEMS, PHASE_ADD_PCT[p]);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
